[hw/rtl/lswos_pkg.sv]
// Shared constants and width helpers for the bordered-square search block.
package lswos_pkg;

    // Default largest matrix side supported by the storage
    localparam int MAX_SIDE_DEF = 64;

    // Matrix side in use after reset
    localparam int SIDE_LEN_RST = 64;

    // Width of the configured side length register
    localparam int SIDE_LEN_W = 7;

    // Result field widths
    localparam int BEST_SIDE_W = 7;
    localparam int CORNER_W    = 6;

    // Index width for a given number of entries, never below one bit
    function automatic int f_idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

[hw/rtl/lswos_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lswos_ram
    import lswos_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [f_idx_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic [f_idx_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry when enabled, read one entry every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/largest_square_with_one_sides.sv]
// Top level: run tracking and sequential downward size search for the largest bordered square.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------------------
//  cell in   | in        | start, busy               | i_cell_value
//  result    | out       | o_valid (one-cycle strobe)| o_best_side, o_top_row, o_left_col,
//            |           |                           | o_matrix_done
//  config    | in        | i_cfg_we                  | i_cfg_side_len
//
//  An accepted cell keeps busy high through ST_LOAD and then ST_SRCH while j sizes are checked,
//  j at most m = max(0, min(hrun, vrun) - best) and fewer when a size fits early; the result
//  beat is on the ports in the first cycle with busy low, and the next cell may be taken in
//  that same cycle.
//  The span is set by the size search: one candidate size per cycle, each reading the
//  column-run RAM and the row-run RAM once, with the compare in the cycle after the read.
//  Reset (synchronous, active low) restores the side length to 64, capped at MAX_SIDE, and
//  starts a new matrix; the run RAMs need no clearing. The result beat cannot be stalled.
module largest_square_with_one_sides
    import lswos_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cell_value,
    input  logic                    i_cfg_we,
    input  logic [SIDE_LEN_W-1:0]   i_cfg_side_len,
    output logic                    o_valid,
    output logic [BEST_SIDE_W-1:0]  o_best_side,
    output logic [CORNER_W-1:0]     o_top_row,
    output logic [CORNER_W-1:0]     o_left_col,
    output logic                    o_matrix_done
);

    // Position, run, store address and scratch widths
    localparam int PW = f_idx_w(MAX_SIDE);
    localparam int RW = $clog2(MAX_SIDE + 1);
    localparam int AW = f_idx_w(MAX_SIDE * MAX_SIDE);
    localparam int CW = (RW > SIDE_LEN_W) ? RW : SIDE_LEN_W;
    localparam int XW = ((PW + 1) > RW) ? (PW + 1) : RW;
    localparam int LAST_RST = ((SIDE_LEN_RST < MAX_SIDE) ? SIDE_LEN_RST : MAX_SIDE) - 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;

    logic [1:0]    r_state, n_state;
    logic          r_cell, n_cell;
    logic [PW-1:0] r_last, n_last;
    logic [PW-1:0] r_row, n_row;
    logic [PW-1:0] r_col, n_col;
    logic [RW-1:0] r_hrun, n_hrun;
    logic [RW-1:0] r_best, n_best;
    logic [PW-1:0] r_brow, n_brow;
    logic [PW-1:0] r_bcol, n_bcol;
    logic [RW-1:0] r_k_iss, n_k_iss;
    logic [RW-1:0] r_k_chk, n_k_chk;
    logic [PW-1:0] r_lc_chk, n_lc_chk;
    logic [PW-1:0] r_tr_chk, n_tr_chk;
    logic          r_chk_vld, n_chk_vld;
    logic          r_out_vld, n_out_vld;
    logic [RW-1:0] r_o_best, n_o_best;
    logic [PW-1:0] r_o_row, n_o_row;
    logic [PW-1:0] r_o_col, n_o_col;
    logic          r_o_done, n_o_done;

    logic [RW-1:0] col_rdata;
    logic [RW-1:0] row_rdata;
    logic [PW-1:0] col_raddr;
    logic [AW-1:0] row_raddr;
    logic [AW-1:0] row_waddr;
    logic          run_we;
    logic [RW-1:0] hrun;
    logic [RW-1:0] vrun;
    logic [RW-1:0] t_size;
    logic [XW-1:0] lc_x;
    logic [XW-1:0] tr_x;
    logic [PW-1:0] lc_iss;
    logic [PW-1:0] tr_iss;
    logic [CW-1:0] side_x;
    logic [CW-1:0] max_x;
    logic [PW-1:0] cfg_last;
    logic          hit;
    logic          finish;
    logic          last_cell;

    // Clamp the written side length and keep it as the last index
    assign side_x = CW'(i_cfg_side_len);
    assign max_x  = CW'(MAX_SIDE);
    always_comb begin
        priority if (side_x == '0) begin
            cfg_last = '0;
        end else if (side_x > max_x) begin
            cfg_last = PW'(max_x - CW'(1));
        end else begin
            cfg_last = PW'(side_x - CW'(1));
        end
    end

    // Runs ending at the current cell
    assign hrun = !r_cell ? '0 : ((r_col != '0) ? (r_hrun + RW'(1)) : RW'(1));
    assign vrun = !r_cell ? '0 : ((r_row != '0) ? (col_rdata + RW'(1)) : RW'(1));
    assign t_size = (hrun < vrun) ? hrun : vrun;

    // Corner of the candidate size being issued
    assign lc_x   = XW'(r_col) + XW'(1) - XW'(r_k_iss);
    assign tr_x   = XW'(r_row) + XW'(1) - XW'(r_k_iss);
    assign lc_iss = PW'(lc_x);
    assign tr_iss = PW'(tr_x);

    // Run RAM addressing
    assign run_we    = (r_state == ST_LOAD);
    assign row_waddr = AW'(r_row * MAX_SIDE) + AW'(r_col);
    assign col_raddr = (r_state == ST_SRCH) ? lc_iss : r_col;
    assign row_raddr = AW'(tr_iss * MAX_SIDE) + AW'(r_col);

    // Left side and top side both long enough for the checked size
    assign hit = r_chk_vld && (col_rdata >= r_k_chk) && (row_rdata >= r_k_chk);
    assign last_cell = (r_row == r_last) && (r_col == r_last);

    lswos_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SIDE)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (r_col),
        .i_wdata (vrun),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    lswos_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (row_waddr),
        .i_wdata (hrun),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Sequencer and search bookkeeping
    always_comb begin
        n_state   = r_state;
        n_cell    = r_cell;
        n_last    = r_last;
        n_row     = r_row;
        n_col     = r_col;
        n_hrun    = r_hrun;
        n_best    = r_best;
        n_brow    = r_brow;
        n_bcol    = r_bcol;
        n_k_iss   = r_k_iss;
        n_k_chk   = r_k_chk;
        n_lc_chk  = r_lc_chk;
        n_tr_chk  = r_tr_chk;
        n_chk_vld = r_chk_vld;
        n_out_vld = 1'b0;
        n_o_best  = r_o_best;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_done  = r_o_done;
        finish    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_we) begin
                    n_last = cfg_last;
                    n_row  = '0;
                    n_col  = '0;
                    n_hrun = '0;
                    n_best = '0;
                    n_brow = '0;
                    n_bcol = '0;
                end else if (start) begin
                    n_cell  = i_cell_value;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_hrun    = hrun;
                n_k_iss   = t_size;
                n_chk_vld = 1'b0;
                n_state   = ST_SRCH;
            end
            ST_SRCH: begin
                if (hit) begin
                    n_best = r_k_chk;
                    n_brow = r_tr_chk;
                    n_bcol = r_lc_chk;
                    finish = 1'b1;
                end else if (r_k_iss > r_best) begin
                    n_k_chk   = r_k_iss;
                    n_lc_chk  = lc_iss;
                    n_tr_chk  = tr_iss;
                    n_chk_vld = 1'b1;
                    n_k_iss   = r_k_iss - RW'(1);
                end else begin
                    finish = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Emit the beat and advance the raster position
        if (finish) begin
            n_out_vld = 1'b1;
            n_o_best  = n_best;
            n_o_row   = n_brow;
            n_o_col   = n_bcol;
            n_o_done  = last_cell;
            n_chk_vld = 1'b0;
            n_state   = ST_IDLE;
            if (last_cell) begin
                n_row  = '0;
                n_col  = '0;
                n_hrun = '0;
                n_best = '0;
                n_brow = '0;
                n_bcol = '0;
            end else if (r_col == r_last) begin
                n_col = '0;
                n_row = r_row + PW'(1);
            end else begin
                n_col = r_col + PW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_last    <= PW'(LAST_RST);
            r_row     <= '0;
            r_col     <= '0;
            r_hrun    <= '0;
            r_best    <= '0;
            r_brow    <= '0;
            r_bcol    <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_row     <= n_row;
            r_col     <= n_col;
            r_hrun    <= n_hrun;
            r_best    <= n_best;
            r_brow    <= n_brow;
            r_bcol    <= n_bcol;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_k_iss  <= n_k_iss;
        r_k_chk  <= n_k_chk;
        r_lc_chk <= n_lc_chk;
        r_tr_chk <= n_tr_chk;
        r_o_best <= n_o_best;
        r_o_row  <= n_o_row;
        r_o_col  <= n_o_col;
        r_o_done <= n_o_done;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_best_side   = BEST_SIDE_W'(r_o_best);
    assign o_top_row     = CORNER_W'(r_o_row);
    assign o_left_col    = CORNER_W'(r_o_col);
    assign o_matrix_done = r_o_done;

`ifndef SYNTHESIS
    // A result beat follows the last busy cycle of an item
    a_beat_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a finished item");

    // Two items cannot finish in adjacent cycles
    a_beat_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats in adjacent cycles");

    // With no square found the corner reads as zero
    a_empty_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_best_side == '0)) |-> ((o_top_row == '0) && (o_left_col == '0)))
        else $error("corner set without a square");

    // Best side never exceeds the matrix side in use
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_best) <= (XW'(r_last) + XW'(1))))
        else $error("best side beyond matrix side");
`endif

endmodule
